// ===== sv/error_dedup_rate_limiter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ERROR_DEDUP_RATE_LIMITER_DEFINES_SVH
`define ERROR_DEDUP_RATE_LIMITER_DEFINES_SVH
// Check that a condition implies a consequence on the next cycle.
`define EDRL_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define EDRL_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
`endif

// ===== sv/edrl_pkg.sv =====
// ----------------------------------------------------------------------------
// edrl_pkg
// Types and constants shared by the error dedup rate limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package edrl_pkg;
   localparam logic [1:0] ACT_REPORT = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_WINDOW = 2'd1;
   localparam logic [1:0] REG_MAXNTF = 2'd2;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic        in_range;
      logic [5:0]  error_code;
      logic [3:0]  subsystem;
      logic [47:0] now_ms;
   } cmd_type;

   typedef struct packed {
      logic        found;
      logic        is_new;
      logic [31:0] hits;
      logic [47:0] first_ms;
      logic [47:0] last_ms;
      logic        entry_was_notified;
      logic        notify_now;
      logic [10:0] unique_count;
      logic [47:0] total_count;
   } rsp_type;
endpackage
`default_nettype wire

// ===== sv/edrl_front.sv =====
// ----------------------------------------------------------------------------
// edrl_front
// Accepts requests, classifies range and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module edrl_front #(
   parameter int CODE_COUNT = 64,
   parameter int SUBSYSTEM_COUNT = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [1:0]       action,
   input  wire logic [5:0]       error_code,
   input  wire logic [3:0]       subsystem,
   input  wire logic [47:0]      now_ms,
   output logic                  cmd_valid,
   output edrl_pkg::cmd_type     cmd,
   input  wire logic             cmd_take
);
   import edrl_pkg::*;
   cmd_type q_ff [2];
   logic    rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type c;
   logic do_push;

   always_comb begin
      c.action = action;
      c.in_range = (32'(error_code) < CODE_COUNT) && (32'(subsystem) < SUBSYSTEM_COUNT);
      c.error_code = error_code;
      c.subsystem = subsystem;
      c.now_ms = now_ms;
      full = cnt_ff == 2'd2;
      cmd_valid = cnt_ff != 2'd0;
      cmd = q_ff[rd_ff];
      do_push = push && !full;
      rd_in = rd_ff ^ cmd_take;
      wr_in = wr_ff ^ do_push;
      cnt_in = cnt_ff + 2'(do_push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= c;
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/edrl_back.sv =====
// ----------------------------------------------------------------------------
// edrl_back
// Sequencer over the entry table and notification log; one result register.
// ----------------------------------------------------------------------------
`default_nettype none
module edrl_back #(
   parameter int CODE_COUNT = 64,
   parameter int SUBSYSTEM_COUNT = 16,
   parameter int LOG_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire edrl_pkg::cmd_type cmd,
   output logic                  cmd_take,
   input  wire logic             notify_enable,
   input  wire logic [31:0]      window_ms,
   input  wire logic [4:0]       max_notify,
   output logic                  rsp_valid,
   output edrl_pkg::rsp_type     rsp,
   input  wire logic             rsp_take
);
   import edrl_pkg::*;
   localparam int DEPTH = CODE_COUNT * SUBSYSTEM_COUNT;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int FW = $clog2(LOG_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXPIRE, S_WRITE, S_CLEAR, S_OUT, S_INIT
   } state_type;
   typedef struct packed {
      logic        valid;
      logic [31:0] count;
      logic [47:0] first;
      logic [47:0] last;
      logic        notified;
   } entry_type;

   entry_type mem [DEPTH];
   logic [47:0] log_mem [LOG_DEPTH];

   state_type   state_ff;
   cmd_type     cmd_ff;
   entry_type   rd_ff, ent_ff;
   logic        new_ff, fire_ff;
   logic [10:0] distinct_ff;
   logic [47:0] total_ff;
   logic [LW-1:0] head_ff;
   logic [FW-1:0] fill_ff;
   logic [47:0] oldest_ff;
   logic [AW-1:0] addr_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic [AW-1:0] idx;
   logic [47:0] start;
   logic [FW-1:0] limit;
   logic [LW:0] slot_sum;
   logic [LW-1:0] wr_slot, head_nx;
   logic        ev, last_addr, out_free, mem_we;
   entry_type   mem_wd;

   always_comb begin
      idx = AW'(32'(cmd.error_code) * SUBSYSTEM_COUNT + 32'(cmd.subsystem));
      start = cmd_ff.now_ms - {16'd0, window_ms};
      limit = (32'(max_notify) > LOG_DEPTH) ? FW'(LOG_DEPTH) : FW'(max_notify);
      slot_sum = (LW+1)'(head_ff) + (LW+1)'(fill_ff);
      wr_slot = (32'(slot_sum) >= LOG_DEPTH) ? LW'(32'(slot_sum) - LOG_DEPTH) : LW'(slot_sum);
      head_nx = (32'(head_ff) == LOG_DEPTH - 1) ? '0 : head_ff + 1'b1;
      ev = cmd_ff.in_range && rd_ff.valid;
      last_addr = (32'(addr_ff) == DEPTH - 1);
      out_free = !rsp_valid_ff || rsp_take;
      cmd_take = (state_ff == S_IDLE) && cmd_valid;
      mem_we = !reset && ((state_ff == S_INIT) || (state_ff == S_CLEAR) ||
               ((state_ff == S_WRITE) && out_free && cmd_ff.action == ACT_REPORT &&
                cmd_ff.in_range));
      mem_wd = (state_ff == S_WRITE) ? ent_ff : '0;
      rsp_valid = rsp_valid_ff;
      rsp = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr_ff] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         addr_ff <= '0;
         distinct_ff <= '0;
         total_ff <= '0;
         head_ff <= '0;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_OUT) || (rsp_valid_ff && !rsp_take);
         case (state_ff)
            S_INIT: begin
               addr_ff <= addr_ff + 1'b1;
               if (last_addr) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_take) begin
                  cmd_ff <= cmd;
                  addr_ff <= (cmd.action == ACT_CLEAR) ? '0 : idx;
                  rd_ff <= mem[idx];
                  oldest_ff <= log_mem[head_ff];
                  state_ff <= (cmd.action == ACT_CLEAR) ? S_CLEAR : S_READ;
               end
            end
            S_CLEAR: begin
               distinct_ff <= '0;
               total_ff <= '0;
               head_ff <= '0;
               fill_ff <= '0;
               if (!last_addr) begin
                  addr_ff <= addr_ff + 1'b1;
               end else if (out_free) begin
                  rsp_ff <= '0;
                  state_ff <= S_OUT;
               end
            end
            S_READ: begin
               new_ff <= 1'b0;
               fire_ff <= 1'b0;
               if (cmd_ff.action == ACT_REPORT && cmd_ff.in_range) begin
                  if (ev) begin
                     ent_ff.count <= rd_ff.count + 32'(rd_ff.count != MAX32);
                     ent_ff.first <= rd_ff.first;
                     ent_ff.notified <= rd_ff.notified;
                     if (rd_ff.count != MAX32 && total_ff != MAX48) total_ff <= total_ff + 1'b1;
                  end else begin
                     ent_ff.count <= 32'd1;
                     ent_ff.first <= cmd_ff.now_ms;
                     ent_ff.notified <= 1'b0;
                     new_ff <= 1'b1;
                     distinct_ff <= distinct_ff + 1'b1;
                     if (total_ff != MAX48) total_ff <= total_ff + 1'b1;
                  end
                  ent_ff.valid <= 1'b1;
                  ent_ff.last <= cmd_ff.now_ms;
                  state_ff <= notify_enable ? S_EXPIRE : S_WRITE;
               end else begin
                  ent_ff <= rd_ff;
                  state_ff <= S_WRITE;
               end
            end
            S_EXPIRE: begin
               if (cmd_ff.now_ms >= {16'd0, window_ms} && fill_ff != '0 && oldest_ff < start) begin
                  head_ff <= head_nx;
                  fill_ff <= fill_ff - 1'b1;
                  oldest_ff <= log_mem[head_nx];
               end else begin
                  if (fill_ff < limit) begin
                     log_mem[wr_slot] <= cmd_ff.now_ms;
                     fill_ff <= fill_ff + 1'b1;
                     fire_ff <= 1'b1;
                     ent_ff.notified <= 1'b1;
                  end
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (out_free) begin
                  rsp_ff.found <= cmd_ff.in_range && (ev || cmd_ff.action == ACT_REPORT);
                  if (cmd_ff.in_range && (ev || cmd_ff.action == ACT_REPORT)) begin
                     rsp_ff.hits <= ent_ff.count;
                     rsp_ff.first_ms <= ent_ff.first;
                     rsp_ff.last_ms <= ent_ff.last;
                     rsp_ff.entry_was_notified <= ent_ff.notified;
                  end else begin
                     rsp_ff.hits <= '0;
                     rsp_ff.first_ms <= '0;
                     rsp_ff.last_ms <= '0;
                     rsp_ff.entry_was_notified <= 1'b0;
                  end
                  rsp_ff.is_new <= new_ff;
                  rsp_ff.notify_now <= fire_ff;
                  rsp_ff.unique_count <= distinct_ff;
                  rsp_ff.total_count <= total_ff;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== sv/edrl_csr.sv =====
// ----------------------------------------------------------------------------
// edrl_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none
module edrl_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic             notify_enable,
   output logic [31:0]      window_ms,
   output logic [4:0]       max_notify
);
   import edrl_pkg::*;
   logic        en_ff;
   logic [31:0] win_ff;
   logic [4:0]  max_ff;
   logic        wr;
   logic [1:0]  ra;

   always_comb begin
      pready = 1'b1;
      wr = psel && penable && pwrite;
      ra = paddr[3:2];
      notify_enable = en_ff;
      window_ms = win_ff;
      max_notify = max_ff;
      case (ra)
         REG_ENABLE: prdata = {31'd0, en_ff};
         REG_WINDOW: prdata = win_ff;
         REG_MAXNTF: prdata = {27'd0, max_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0; win_ff <= 32'd5000; max_ff <= 5'd3;
      end else if (wr && paddr[1:0] == 2'd0) begin
         case (ra)
            REG_ENABLE: en_ff <= pwdata[0];
            REG_WINDOW: win_ff <= pwdata;
            REG_MAXNTF: max_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== sv/error_dedup_rate_limiter.sv =====
// A request passes the front queue and the back end's read, expire (in-range report with
// notification on, repeated per expired log time), write and output steps; a clear walks
// the table. The back end takes a new request only when idle; a result waiting for pop
// holds it at its write step or at the end of a clear. Reset: synchronous, active high;
// empties log, queues and totals, then a table clearing pass runs before the first item.
// ----------------------------------------------------------------------------
// error_dedup_rate_limiter
// Error event aggregator with a sliding-window notification limiter.
// ----------------------------------------------------------------------------
`default_nettype none
module error_dedup_rate_limiter #(
   parameter int CODE_COUNT = 64,
   parameter int SUBSYSTEM_COUNT = 16,
   parameter int LOG_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_action,
   input  wire logic [5:0]  req_error_code,
   input  wire logic [3:0]  req_subsystem,
   input  wire logic [47:0] req_now_ms,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_found,
   output logic             rsp_is_new,
   output logic [31:0]      rsp_occurrence_count,
   output logic [47:0]      rsp_first_seen_ms,
   output logic [47:0]      rsp_last_seen_ms,
   output logic             rsp_entry_was_notified,
   output logic             rsp_notify_now,
   output logic [10:0]      rsp_unique_count,
   output logic [47:0]      rsp_total_count,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import edrl_pkg::*;
   logic cmd_valid, cmd_take, rsp_valid, en;
   logic [31:0] win;
   logic [4:0] mx;
   cmd_type cmd;
   rsp_type rsp;

   edrl_csr u_csr (.clock, .reset, .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .pready(csr_pready), .notify_enable(en),
      .window_ms(win), .max_notify(mx));

   edrl_front #(.CODE_COUNT(CODE_COUNT), .SUBSYSTEM_COUNT(SUBSYSTEM_COUNT)) u_front (
      .clock, .reset, .push(req_push), .full(req_full), .action(req_action),
      .error_code(req_error_code), .subsystem(req_subsystem), .now_ms(req_now_ms),
      .cmd_valid, .cmd, .cmd_take);

   edrl_back #(.CODE_COUNT(CODE_COUNT), .SUBSYSTEM_COUNT(SUBSYSTEM_COUNT),
      .LOG_DEPTH(LOG_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take, .notify_enable(en),
      .window_ms(win), .max_notify(mx), .rsp_valid, .rsp, .rsp_take(rsp_pop));

   always_comb begin
      rsp_empty = !rsp_valid;
      rsp_found = rsp.found;
      rsp_is_new = rsp.is_new;
      rsp_occurrence_count = rsp.hits;
      rsp_first_seen_ms = rsp.first_ms;
      rsp_last_seen_ms = rsp.last_ms;
      rsp_entry_was_notified = rsp.entry_was_notified;
      rsp_notify_now = rsp.notify_now;
      rsp_unique_count = rsp.unique_count;
      rsp_total_count = rsp.total_count;
   end
endmodule
`default_nettype wire

// ===== sv/edrl_checker.sv =====
// ----------------------------------------------------------------------------
// edrl_checker
// Port-level checks of the error dedup rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "error_dedup_rate_limiter_defines.svh"
module edrl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic        rsp_found,
   input wire logic        rsp_is_new,
   input wire logic        rsp_notify_now,
   input wire logic [31:0] rsp_occurrence_count,
   input wire logic        csr_pready
);
   `EDRL_ASSERT_NOW(a_new_found, clock, reset, !rsp_empty && rsp_is_new, rsp_found)
   `EDRL_ASSERT_NOW(a_new_one, clock, reset, !rsp_empty && rsp_is_new, rsp_occurrence_count == 32'd1)
   `EDRL_ASSERT_NOW(a_ntf_found, clock, reset, !rsp_empty && rsp_notify_now, rsp_found)
   `EDRL_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
   `EDRL_ASSERT_NOW(a_ready, clock, reset, 1'b1, csr_pready)
endmodule

bind error_dedup_rate_limiter edrl_checker u_chk (.clock, .reset, .rsp_empty, .rsp_pop,
   .rsp_found, .rsp_is_new, .rsp_notify_now, .rsp_occurrence_count, .csr_pready);
`default_nettype wire

// ===== sim/error_dedup_rate_limiter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// error_dedup_rate_limiter_tb
// Self-checking bench: drives report, query and clear requests with random
// gaps and result stalls, predicts every result from a behavioral copy of
// the table and the notification log, and compares each transfer by field.
// ----------------------------------------------------------------------------
`default_nettype none
module error_dedup_rate_limiter_tb;
   import edrl_pkg::*;

   localparam int TABLE_SIZE = 1024;
   localparam int LOG_SIZE = 16;
   localparam int EXP_DEPTH = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_action = ACT_QUERY;
   logic [5:0]  req_error_code = '0;
   logic [3:0]  req_subsystem = '0;
   logic [47:0] req_now_ms = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_found;
   logic        rsp_is_new;
   logic [31:0] rsp_occurrence_count;
   logic [47:0] rsp_first_seen_ms;
   logic [47:0] rsp_last_seen_ms;
   logic        rsp_entry_was_notified;
   logic        rsp_notify_now;
   logic [10:0] rsp_unique_count;
   logic [47:0] rsp_total_count;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   error_dedup_rate_limiter dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic        cfg_enable;
   logic [31:0] cfg_window;
   logic [4:0]  cfg_max;
   logic        tbl_valid [TABLE_SIZE];
   logic [31:0] tbl_count [TABLE_SIZE];
   logic [47:0] tbl_first [TABLE_SIZE];
   logic [47:0] tbl_last [TABLE_SIZE];
   logic        tbl_notified [TABLE_SIZE];
   logic [10:0] distinct_total;
   logic [47:0] occurrence_total;
   logic [47:0] notify_times [LOG_SIZE];
   logic [3:0]  log_head;
   logic [4:0]  log_fill;

   rsp_type     expected_results [EXP_DEPTH];
   int          exp_wr = 0;
   int          exp_rd = 0;
   logic [47:0] clock_ms;
   int          mismatches = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          notifies_seen = 0;

   function automatic logic notify_allowed(input logic [47:0] now);
      logic [47:0] start;
      int limit;
      if (now >= {16'd0, cfg_window}) begin
         start = now - {16'd0, cfg_window};
         while (log_fill > 0 && notify_times[log_head] < start) begin
            log_head = log_head + 4'd1;
            log_fill = log_fill - 5'd1;
         end
      end
      limit = (cfg_max > LOG_SIZE) ? LOG_SIZE : cfg_max;
      if (log_fill >= limit) return 1'b0;
      notify_times[4'(log_head + log_fill)] = now;
      log_fill = log_fill + 5'd1;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_result(input logic [1:0] act, input logic [5:0] code,
                                               input logic [3:0] sub, input logic [47:0] now);
      rsp_type r;
      int idx;
      idx = code * 16 + sub;
      r = '0;
      if (act == ACT_CLEAR) begin
         foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
         distinct_total = '0;
         occurrence_total = '0;
         log_head = '0;
         log_fill = '0;
      end else if (act == ACT_REPORT) begin
         if (tbl_valid[idx]) begin
            if (tbl_count[idx] != MAX32) begin
               tbl_count[idx]++;
               if (occurrence_total != MAX48) occurrence_total++;
            end
            tbl_last[idx] = now;
         end else begin
            tbl_valid[idx] = 1'b1;
            tbl_count[idx] = 32'd1;
            tbl_first[idx] = now;
            tbl_last[idx] = now;
            tbl_notified[idx] = 1'b0;
            distinct_total++;
            if (occurrence_total != MAX48) occurrence_total++;
            r.is_new = 1'b1;
         end
         if (cfg_enable && notify_allowed(now)) begin
            tbl_notified[idx] = 1'b1;
            r.notify_now = 1'b1;
         end
      end
      if (act != ACT_CLEAR && tbl_valid[idx]) begin
         r.found = 1'b1;
         r.hits = tbl_count[idx];
         r.first_ms = tbl_first[idx];
         r.last_ms = tbl_last[idx];
         r.entry_was_notified = tbl_notified[idx];
      end
      r.unique_count = distinct_total;
      r.total_count = occurrence_total;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic [1:0] act, input logic [5:0] code,
                               input logic [3:0] sub, input logic [47:0] now);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_action <= act;
      req_error_code <= code;
      req_subsystem <= sub;
      req_now_ms <= now;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_results[exp_wr % EXP_DEPTH] = predict_result(act, code, sub, now);
      exp_wr++;
      items_sent++;
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_ENABLE: cfg_enable = value[0];
         REG_WINDOW: cfg_window = value;
         default:    cfg_max = value[4:0];
      endcase
      @(posedge clock);
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_push <= 1'b0;
      while (exp_wr != exp_rd && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(input logic en, input logic [31:0] win, input logic [4:0] mx);
      wait_idle();
      write_register(REG_ENABLE, {31'd0, en});
      write_register(REG_WINDOW, win);
      write_register(REG_MAXNTF, {27'd0, mx});
   endtask

   task automatic advance_time(input int span);
      clock_ms = clock_ms + 48'(span);
   endtask

   task automatic test_directed_extremes();
      send_request(ACT_QUERY, 6'd0, 4'd0, 48'd0);
      send_request(ACT_REPORT, 6'd0, 4'd0, 48'd0);
      send_request(ACT_REPORT, 6'd63, 4'd15, 48'd10);
      send_request(ACT_REPORT, 6'd63, 4'd15, 48'd20);
      send_request(ACT_QUERY, 6'd63, 4'd15, 48'd20);
      send_request(2'd3, 6'd0, 4'd0, 48'd30);
      send_request(2'd3, 6'd42, 4'd5, 48'd30);
      send_request(ACT_REPORT, 6'h2A, 4'h5, 48'hAAAA_AAAA_AAAA);
      send_request(ACT_REPORT, 6'h15, 4'hA, 48'h5555_5555_5555);
      send_request(ACT_CLEAR, 6'd0, 4'd0, 48'h5555_5555_5555);
      send_request(ACT_QUERY, 6'h2A, 4'h5, 48'h5555_5555_5556);
      send_request(ACT_REPORT, 6'd1, 4'd1, MAX48);
      send_request(ACT_REPORT, 6'd1, 4'd1, MAX48);
      send_request(ACT_CLEAR, 6'd63, 4'd15, MAX48);
      clock_ms = 48'd0;
   endtask

   task automatic test_notify_window();
      // fill, saturate and expire the log, including time going backwards
      configure(1'b1, 32'd100, 5'd3);
      clock_ms = 48'd0;
      for (int i = 0; i < 12; i++) begin
         send_request(ACT_REPORT, 6'(i % 3), 4'd2, clock_ms);
         advance_time(30);
      end
      send_request(ACT_REPORT, 6'd5, 4'd5, 48'd10);
      send_request(ACT_REPORT, 6'd5, 4'd5, 48'd2000);
      configure(1'b1, 32'd0, 5'd31);
      for (int i = 0; i < 20; i++) send_request(ACT_REPORT, 6'd7, 4'(i), 48'd3000);
      configure(1'b1, 32'hFFFF_FFFF, 5'd0);
      send_request(ACT_REPORT, 6'd8, 4'd8, MAX48);
      send_request(ACT_CLEAR, 6'd0, 4'd0, MAX48);
   endtask

   task automatic test_random_traffic(input int count);
      int roll;
      logic [5:0] code;
      logic [3:0] sub;
      logic [1:0] act;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 999);
         if (roll < 3) act = ACT_CLEAR;
         else if (roll < 700) act = ACT_REPORT;
         else act = ($urandom_range(0, 3) == 0) ? 2'd3 : ACT_QUERY;
         if ($urandom_range(0, 3) != 0) begin
            code = 6'($urandom_range(0, 7));
            sub = 4'($urandom_range(0, 3));
         end else begin
            code = 6'($urandom);
            sub = 4'($urandom);
         end
         roll = $urandom_range(0, 99);
         if (roll < 60) advance_time($urandom_range(0, 20));
         else if (roll < 95) advance_time($urandom_range(20, 300));
         else advance_time($urandom_range(300, 3000));
         if ($urandom_range(0, 99) == 0)
            send_request(act, code, sub, clock_ms - 48'($urandom_range(0, 200)));
         else
            send_request(act, code, sub, clock_ms);
      end
   endtask

   task automatic test_random_phases();
      configure(1'b1, 32'd200, 5'd4);
      test_random_traffic(450);
      configure(1'b1, 32'd50, 5'd16);
      test_random_traffic(450);
      configure(1'b0, 32'd1000, 5'd2);
      test_random_traffic(300);
      configure(1'b1, 32'd800, 5'd1);
      test_random_traffic(300);
      configure(1'b1, 32'($urandom), 5'($urandom));
      test_random_traffic(300);
   endtask

   task automatic test_wide_times();
      // high timestamp bits and a count-saturation-free sweep
      configure(1'b1, 32'd5000, 5'd3);
      for (int i = 0; i < 10; i++)
         send_request(ACT_REPORT, 6'($urandom), 4'($urandom), 48'hF000_0000_0000 + 48'(i));
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (!rsp_empty && rsp_pop) begin
            got = '{rsp_found, rsp_is_new, rsp_occurrence_count, rsp_first_seen_ms,
                    rsp_last_seen_ms, rsp_entry_was_notified, rsp_notify_now,
                    rsp_unique_count, rsp_total_count};
            results_seen++;
            if (got.notify_now) notifies_seen++;
            if (exp_wr == exp_rd) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transfer: %p", got);
            end else begin
               want = expected_results[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d mismatch", results_seen);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
               end
            end
         end
         if ($urandom_range(0, 9) < 7) rsp_pop <= 1'b1;
         else rsp_pop <= ($urandom_range(0, 4) == 0);
      end
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      cfg_enable = 1'b0;
      cfg_window = 32'd5000;
      cfg_max = 5'd3;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      distinct_total = '0;
      occurrence_total = '0;
      log_head = '0;
      log_fill = '0;
      clock_ms = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_notify_window();
      test_random_phases();
      test_wide_times();
      wait_idle();
      if (exp_wr != exp_rd) mismatches++;
      $display("Sent %0d requests, checked %0d results, %0d notifications fired.",
               items_sent, results_seen, notifies_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/edrl_pkg.sv
sv/edrl_front.sv
sv/edrl_back.sv
sv/edrl_csr.sv
sv/error_dedup_rate_limiter.sv
sv/edrl_checker.sv
sim/error_dedup_rate_limiter_tb.sv
